// ----- rtl/rnd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnd_pkg
// Types and constants shared by the receive notification deframer.
// ----------------------------------------------------------------------------
package rnd_pkg;

  localparam int FIELD_WIDTH = 16;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [2:0] FLD_LINK   = 3'd0;
  localparam logic [2:0] FLD_LENGTH = 3'd1;
  localparam logic [2:0] FLD_OCT0   = 3'd2;
  localparam logic [2:0] FLD_OCT1   = 3'd3;
  localparam logic [2:0] FLD_OCT2   = 3'd4;
  localparam logic [2:0] FLD_OCT3   = 3'd5;
  localparam logic [2:0] FLD_PORT   = 3'd6;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FIELDS  = 2'd1,
    PH_SKIP_LF = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  link_id;
    logic [15:0] payload_length;
    logic [7:0]  octet_first;
    logic [7:0]  octet_second;
    logic [7:0]  octet_third;
    logic [7:0]  octet_fourth;
    logic [15:0] remote_port;
    logic [7:0]  payload_byte;
    logic        last;
  } out_beat_t;

endpackage

// ----- rtl/receive_notification_deframer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_notification_deframer_core
// Parses the header fields of a data-receive notification and passes its
// payload bytes, one input beat per cycle while in_stall is low.
// ----------------------------------------------------------------------------
// output: a result is registered in out_beat_r, or in the skid register while out_stall holds out_beat_r
// throughput: one input beat per cycle; in_stall rises only when the output
//   register and the skid register both hold a result
// reset: synchronous active-low rst_n clears parser state and both valids
// ----------------------------------------------------------------------------
module receive_notification_deframer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rnd_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output rnd_pkg::out_beat_t  out_beat
);

  localparam int AW = rnd_pkg::FIELD_WIDTH;

  rnd_pkg::phase_t    phase_r, phase_nxt;
  logic [2:0]         field_index_r, field_index_nxt;
  logic [AW-1:0]      acc_r, acc_nxt;
  logic [7:0]         held_link_r, held_link_nxt;
  logic [15:0]        held_length_r, held_length_nxt;
  logic [7:0]         held_octets_r [4];
  logic [7:0]         held_octets_nxt [4];
  logic [15:0]        held_port_r, held_port_nxt;
  logic [15:0]        bytes_left_r, bytes_left_nxt;

  logic               out_valid_r;
  rnd_pkg::out_beat_t out_beat_r;
  logic               skid_valid_r;
  rnd_pkg::out_beat_t skid_beat_r;

  logic               in_fire;
  logic               res_valid;
  rnd_pkg::out_beat_t res_beat;
  logic               is_digit;
  logic [AW+3:0]      acc_mul;
  logic [15:0]        acc_wide;
  logic               fin;

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  assign is_digit = (in_beat.rx_byte >= rnd_pkg::CHAR_ZERO) &&
                    (in_beat.rx_byte <= rnd_pkg::CHAR_NINE);
  // times ten as two shifts and an add
  assign acc_mul  = ((AW+4)'(acc_r) << 3) + ((AW+4)'(acc_r) << 1) +
                    (AW+4)'(in_beat.rx_byte[3:0]);
  assign acc_wide = 16'(acc_r);
  assign fin      = (bytes_left_r <= 16'd1);

  always_comb begin
    phase_nxt       = phase_r;
    field_index_nxt = field_index_r;
    acc_nxt         = acc_r;
    held_link_nxt   = held_link_r;
    held_length_nxt = held_length_r;
    held_octets_nxt = held_octets_r;
    held_port_nxt   = held_port_r;
    bytes_left_nxt  = bytes_left_r;
    res_valid       = 1'b0;

    res_beat.kind           = rnd_pkg::KIND_HEADER;
    res_beat.link_id        = held_link_r;
    res_beat.payload_length = held_length_r;
    res_beat.octet_first    = held_octets_r[0];
    res_beat.octet_second   = held_octets_r[1];
    res_beat.octet_third    = held_octets_r[2];
    res_beat.octet_fourth   = held_octets_r[3];
    res_beat.remote_port    = held_port_r;
    res_beat.payload_byte   = 8'd0;
    res_beat.last           = 1'b0;

    if (in_fire) begin
      if (in_beat.frame_start) begin
        phase_nxt       = rnd_pkg::PH_FIELDS;
        field_index_nxt = rnd_pkg::FLD_LINK;
        acc_nxt         = '0;
      end else begin
        case (phase_r)
          rnd_pkg::PH_FIELDS: begin
            if (is_digit) begin
              if (acc_mul[AW+3:AW] != 4'd0) begin
                acc_nxt = '1;
              end else begin
                acc_nxt = acc_mul[AW-1:0];
              end
            end else begin
              case (field_index_r)
                rnd_pkg::FLD_LINK:   held_link_nxt      = acc_wide[7:0];
                rnd_pkg::FLD_LENGTH: held_length_nxt    = acc_wide[15:0];
                rnd_pkg::FLD_OCT0:   held_octets_nxt[0] = acc_wide[7:0];
                rnd_pkg::FLD_OCT1:   held_octets_nxt[1] = acc_wide[7:0];
                rnd_pkg::FLD_OCT2:   held_octets_nxt[2] = acc_wide[7:0];
                rnd_pkg::FLD_OCT3:   held_octets_nxt[3] = acc_wide[7:0];
                default:             held_port_nxt      = acc_wide[15:0];
              endcase
              acc_nxt = '0;
              if (field_index_r >= rnd_pkg::FLD_PORT) begin
                field_index_nxt = rnd_pkg::FLD_LINK;
                phase_nxt       = rnd_pkg::PH_SKIP_LF;
              end else begin
                field_index_nxt = field_index_r + 3'd1;
              end
            end
          end
          rnd_pkg::PH_SKIP_LF: begin
            res_valid = 1'b1;
            if (held_length_r == 16'd0) begin
              phase_nxt     = rnd_pkg::PH_IDLE;
              res_beat.last = 1'b1;
            end else begin
              bytes_left_nxt = held_length_r;
              phase_nxt      = rnd_pkg::PH_PAYLOAD;
            end
          end
          rnd_pkg::PH_PAYLOAD: begin
            res_valid             = 1'b1;
            res_beat.kind         = rnd_pkg::KIND_PAYLOAD;
            res_beat.payload_byte = in_beat.rx_byte;
            res_beat.last         = fin;
            if (fin) begin
              bytes_left_nxt = 16'd0;
              phase_nxt      = rnd_pkg::PH_IDLE;
            end else begin
              bytes_left_nxt = bytes_left_r - 16'd1;
            end
          end
          default: begin
            phase_nxt = rnd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= rnd_pkg::PH_IDLE;
      field_index_r <= rnd_pkg::FLD_LINK;
      acc_r         <= '0;
      held_link_r   <= 8'd0;
      held_length_r <= 16'd0;
      held_octets_r <= '{default: 8'd0};
      held_port_r   <= 16'd0;
      bytes_left_r  <= 16'd0;
    end else begin
      phase_r       <= phase_nxt;
      field_index_r <= field_index_nxt;
      acc_r         <= acc_nxt;
      held_link_r   <= held_link_nxt;
      held_length_r <= held_length_nxt;
      held_octets_r <= held_octets_nxt;
      held_port_r   <= held_port_nxt;
      bytes_left_r  <= bytes_left_nxt;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_beat_r   <= skid_beat_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
        out_beat_r  <= res_beat;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
      skid_beat_r  <= res_beat;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rnd_pkg::PH_PAYLOAD) |-> (bytes_left_r != 16'd0))
    else $error("payload phase with no bytes left");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    field_index_r <= rnd_pkg::FLD_PORT)
    else $error("field index past port field");

  a_empty_header_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_beat_r.kind == rnd_pkg::KIND_HEADER) && out_beat_r.last)
      |-> (out_beat_r.payload_length == 16'd0))
    else $error("header marked last with nonzero length");

endmodule

// ----- tb/receive_notification_deframer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_notification_deframer_core_test
// Feeds data-receive notification text into the deframer and checks every
// header and payload beat against an in-bench parser. A short directed table
// covers empty fields, odd terminators, saturation and a one-byte payload.
// Random notifications follow, some cut short by a new frame start, some with
// saturated lengths. Both channels idle at random, and the receiver holds off
// once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module receive_notification_deframer_core_test;
  import rnd_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam logic [7:0] LINE_FEED = 8'h0A;
  localparam logic [7:0] COMMA = 8'h2C;
  localparam logic [FIELD_WIDTH-1:0] FIELD_MAX = {FIELD_WIDTH{1'b1}};

  localparam out_beat_t NO_RESULT = '0;
  localparam out_beat_t HDR_EMPTY = '{kind: KIND_HEADER, last: 1'b1, default: '0};
  localparam out_beat_t HDR_SATURATED = '{kind: KIND_HEADER, link_id: 8'hFF,
                                          payload_length: 16'd1, default: '0};
  localparam out_beat_t BODY_ONE_BYTE = '{kind: KIND_PAYLOAD, link_id: 8'hFF,
                                          payload_length: 16'd1, payload_byte: 8'hFF,
                                          last: 1'b1, default: '0};

  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 84;
  int          hold_left = 0;
  int          errors = 0;
  int          cycles = 0;

  out_beat_t pending_results [$];
  in_beat_t  byte_stream [$];

  // parser state
  phase_t                 parse_phase = PH_IDLE;
  logic [2:0]             field_sel = FLD_LINK;
  logic [FIELD_WIDTH-1:0] field_acc = '0;
  logic [7:0]             hdr_link = '0;
  logic [15:0]            hdr_length = '0;
  logic [7:0]             hdr_octet [4] = '{default: 8'h00};
  logic [15:0]            hdr_port = '0;
  logic [15:0]            payload_left = '0;

  dir_row_t directed_rows [27] = '{
    '{'{8'h41, 1'b0}, 1'b0, NO_RESULT},      // byte while idle, ignored
    '{'{8'h3A, 1'b1}, 1'b0, NO_RESULT},
    '{'{8'h2C, 1'b0}, 1'b0, NO_RESULT},      // seven empty fields, odd terminators
    '{'{8'h2F, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h3A, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h2E, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h2C, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h0A, 1'b0}, 1'b1, HDR_EMPTY},
    '{'{8'h2B, 1'b1}, 1'b0, NO_RESULT},
    '{'{8'h39, 1'b0}, 1'b0, NO_RESULT},      // link 99999 saturates
    '{'{8'h39, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h39, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h39, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h39, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h2C, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h30, 1'b0}, 1'b0, NO_RESULT},      // length 01
    '{'{8'h31, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h2C, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h2C, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h2C, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h2C, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h2C, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h0D, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h0A, 1'b0}, 1'b1, HDR_SATURATED},
    '{'{8'hFF, 1'b0}, 1'b1, BODY_ONE_BYTE}
  };

  receive_notification_deframer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic out_beat_t held_header(logic kind, logic [7:0] data, logic fin);
    out_beat_t r;
    r.kind = kind;
    r.link_id = hdr_link;
    r.payload_length = hdr_length;
    r.octet_first = hdr_octet[0];
    r.octet_second = hdr_octet[1];
    r.octet_third = hdr_octet[2];
    r.octet_fourth = hdr_octet[3];
    r.remote_port = hdr_port;
    r.payload_byte = data;
    r.last = fin;
    return r;
  endfunction

  function automatic bit deframe_byte(input in_beat_t b, output out_beat_t r);
    logic [FIELD_WIDTH+3:0] grown;
    logic                   fin;
    r = '0;
    if (b.frame_start) begin
      parse_phase = PH_FIELDS;
      field_sel = FLD_LINK;
      field_acc = '0;
      return 1'b0;
    end
    case (parse_phase)
      PH_FIELDS: begin
        if (b.rx_byte >= CHAR_ZERO && b.rx_byte <= CHAR_NINE) begin
          grown = (FIELD_WIDTH+4)'(field_acc * 10 + (b.rx_byte - CHAR_ZERO));
          field_acc = (grown > FIELD_MAX) ? FIELD_MAX : grown[FIELD_WIDTH-1:0];
        end else begin
          case (field_sel)
            FLD_LINK:   hdr_link = field_acc[7:0];
            FLD_LENGTH: hdr_length = field_acc[15:0];
            FLD_OCT0:   hdr_octet[0] = field_acc[7:0];
            FLD_OCT1:   hdr_octet[1] = field_acc[7:0];
            FLD_OCT2:   hdr_octet[2] = field_acc[7:0];
            FLD_OCT3:   hdr_octet[3] = field_acc[7:0];
            default:    hdr_port = field_acc[15:0];
          endcase
          field_acc = '0;
          if (field_sel >= FLD_PORT) begin
            field_sel = FLD_LINK;
            parse_phase = PH_SKIP_LF;
          end else begin
            field_sel++;
          end
        end
        return 1'b0;
      end
      PH_SKIP_LF: begin
        if (hdr_length == 16'd0) begin
          parse_phase = PH_IDLE;
          r = held_header(KIND_HEADER, 8'h00, 1'b1);
        end else begin
          payload_left = hdr_length;
          parse_phase = PH_PAYLOAD;
          r = held_header(KIND_HEADER, 8'h00, 1'b0);
        end
        return 1'b1;
      end
      PH_PAYLOAD: begin
        fin = (payload_left <= 16'd1);
        r = held_header(KIND_PAYLOAD, b.rx_byte, fin);
        if (fin) begin
          payload_left = '0;
          parse_phase = PH_IDLE;
        end else begin
          payload_left--;
        end
        return 1'b1;
      end
      default: begin
        parse_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // negative value means a field with no digits
  function automatic int random_field_value();
    case ($urandom_range(9))
      0:       return -1;
      1:       return $urandom_range(65530, 9999999);
      2, 3, 4: return $urandom_range(255);
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic void append_field(ref in_beat_t text [$], input int value);
    string    digits;
    in_beat_t b;
    if (value >= 0) begin
      digits = $sformatf("%0d", value);
      if ($urandom_range(7) == 0) text.push_back(in_beat_t'{CHAR_ZERO, 1'b0});
      for (int i = 0; i < digits.len(); i++) text.push_back(in_beat_t'{digits[i], 1'b0});
    end
    b.frame_start = 1'b0;
    if ($urandom_range(1)) begin
      b.rx_byte = COMMA;
    end else begin
      do b.rx_byte = 8'($urandom);
      while (b.rx_byte >= CHAR_ZERO && b.rx_byte <= CHAR_NINE);
    end
    text.push_back(b);
  endfunction

  // returns the number of notification beats queued, trailing filler bytes not counted
  function automatic int queue_notification();
    in_beat_t notice [$];
    int       length_text;
    int       body;
    int       keep;
    notice.push_back(in_beat_t'{8'($urandom), 1'b1});
    append_field(notice, random_field_value());
    case ($urandom_range(19))
      0:       length_text = -1;
      1:       length_text = $urandom_range(70000, 999999);
      2, 3:    length_text = $urandom_range(7, 40);
      default: length_text = $urandom_range(6);
    endcase
    append_field(notice, length_text);
    repeat (5) append_field(notice, random_field_value());
    notice.push_back(in_beat_t'{($urandom_range(7) == 0) ? 8'($urandom) : LINE_FEED, 1'b0});
    // saturated length never completes, the next frame start abandons it
    if (length_text > 65535) body = $urandom_range(1, 12);
    else if (length_text < 0) body = 0;
    else body = length_text;
    repeat (body) notice.push_back(in_beat_t'{8'($urandom), 1'b0});
    if ($urandom_range(7) == 0) begin
      keep = $urandom_range(1, notice.size() - 1);
      notice = notice[0:keep-1];
    end
    foreach (notice[i]) byte_stream.push_back(notice[i]);
    if (length_text <= 65535 && $urandom_range(5) == 0) begin
      repeat ($urandom_range(1, 3)) byte_stream.push_back(in_beat_t'{8'($urandom), 1'b0});
    end
    return notice.size();
  endfunction

  task automatic offer_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    out_beat_t predicted;
    bit        has_result;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_beat <= in_beat_t'(9'($urandom_range(511)));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has_result = deframe_byte(b, predicted);
    if (has_result) pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: kind %0d payload_byte %0d",
               out_beat.kind, out_beat.payload_byte);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_beat.kind));
        check_field("link_id", 32'(want.link_id), 32'(out_beat.link_id));
        check_field("payload_length", 32'(want.payload_length),
                    32'(out_beat.payload_length));
        check_field("octet_first", 32'(want.octet_first), 32'(out_beat.octet_first));
        check_field("octet_second", 32'(want.octet_second), 32'(out_beat.octet_second));
        check_field("octet_third", 32'(want.octet_third), 32'(out_beat.octet_third));
        check_field("octet_fourth", 32'(want.octet_fourth), 32'(out_beat.octet_fourth));
        check_field("remote_port", 32'(want.remote_port), 32'(out_beat.remote_port));
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_beat.payload_byte));
        check_field("last", 32'(want.last), 32'(out_beat.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL receive_notification_deframer_core");
      $finish;
    end
  end

  initial begin : stimulus
    int queued;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      offer_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 15 : (p == 1) ? 84 : 0;
      recv_idle_pct = (p == 0) ? 84 : (p == 1) ? 15 : 0;
      if (p == 2) hold_left = 400;
      queued = 0;
      while (queued < 200) queued += queue_notification();
      while (byte_stream.size() != 0) offer_beat(byte_stream.pop_front(), 1'b0, NO_RESULT);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS receive_notification_deframer_core");
    end else begin
      $display("FAIL receive_notification_deframer_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rnd_pkg.sv
rtl/receive_notification_deframer_core.sv
tb/receive_notification_deframer_core_test.sv
